// File: rtl/aspp_pkg.sv
// Shared types and constants of the AS_PATH segment parser.
package aspp_pkg;

   // Reject cause codes carried on the result channel.
   localparam logic [2:0] CAUSE_OK       = 3'd0;
   localparam logic [2:0] CAUSE_ODD_LEN  = 3'd1;
   localparam logic [2:0] CAUSE_NEAR_END = 3'd2;
   localparam logic [2:0] CAUSE_OVERRUN  = 3'd3;
   localparam logic [2:0] CAUSE_ZERO_CNT = 3'd4;
   localparam logic [2:0] CAUSE_BAD_TYPE = 3'd5;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_TYPE  = 3'b001,
      PH_COUNT = 3'b010,
      PH_VALUE = 3'b100
   } phase_type;

   // One byte as classified by the front end.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] path_length;
      logic [16:0] pos_p1;     // byte position plus one
      logic        last;       // last byte of the path
      logic        odd_first;  // first byte of a path with odd length
      logic        near_end;   // two or fewer bytes left, counting this one
   } cls_type;

   // One result item.
   typedef struct packed {
      logic [31:0] as_number;
      logic [1:0]  segment_kind;
      logic        segment_end;
      logic        path_end;
      logic [2:0]  reject_cause;
   } rsp_type;

endpackage

// File: rtl/aspp_front.sv
// Front end: accepts bytes, tracks the path position and classifies each byte.
module aspp_front
   import aspp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  data_byte,
   input  logic [15:0] path_length,
   output logic        head_valid,
   output cls_type     head,
   input  logic        head_pop
);

   logic [15:0] pos_ff, pos_in;
   cls_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        do_pop;
   cls_type     cls;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign do_pop     = head_pop && head_valid;

   // Classify the incoming byte against its position in the path.
   always_comb begin
      cls.data_byte   = data_byte;
      cls.path_length = path_length;
      cls.pos_p1      = {1'b0, pos_ff} + 17'd1;
      cls.last        = (cls.pos_p1 >= {1'b0, path_length});
      cls.odd_first   = (pos_ff == 16'd0) && path_length[0];
      cls.near_end    = (({1'b0, pos_ff} + 17'd2) >= {1'b0, path_length});
   end

   // Position counter wraps to zero after the last byte of a path.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = cls.last ? 16'd0 : cls.pos_p1[15:0];
      end
   end

   // Queue pointers toward the back end.
   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 16'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         pos_ff    <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: rtl/aspp_back.sv
// Back end: runs the segment parser on classified bytes and queues the results.
module aspp_back
   import aspp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    four_byte_as,
   input  logic    head_valid,
   input  cls_type head,
   output logic    head_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_head
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] acc_ff, acc_in;
   logic        skip_ff, skip_in;

   rsp_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic        out_full;
   logic        fire;
   logic        res_valid;
   rsp_type     res;
   logic        do_push;
   logic        do_pop;

   logic [9:0]  seg_bytes;
   logic [17:0] seg_end;
   logic        overrun;
   logic [31:0] acc_next;
   logic        value_done;
   logic [7:0]  left_dec;
   logic [2:0]  cause;

   assign out_full  = (count_ff == 2'd2);
   assign fire      = head_valid && !out_full;
   assign head_pop  = fire;
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_head  = q_ff[rd_ptr_ff];
   assign do_push   = fire && res_valid;
   assign do_pop    = rsp_pop && !rsp_empty;

   // Segment extent check and value assembly.
   always_comb begin
      seg_bytes  = four_byte_as ? {head.data_byte, 2'b00} : {1'b0, head.data_byte, 1'b0};
      seg_end    = {1'b0, head.pos_p1} + {8'd0, seg_bytes};
      overrun    = (seg_end > {2'b00, head.path_length});
      acc_next   = {acc_ff[23:0], head.data_byte};
      value_done = (({1'b0, idx_ff} + 3'd1) >= (four_byte_as ? 3'd4 : 3'd2));
      left_dec   = left_ff - 8'd1;
   end

   // Parser step for the byte at the head of the input queue.
   always_comb begin
      phase_in    = phase_ff;
      cur_type_in = cur_type_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      skip_in     = skip_ff;
      res_valid   = 1'b0;
      res         = '0;
      cause       = CAUSE_OK;

      if (!skip_ff) begin
         if (head.odd_first) begin
            cause = CAUSE_ODD_LEN;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  if (head.near_end) begin
                     cause = CAUSE_NEAR_END;
                  end else begin
                     cur_type_in = head.data_byte;
                     phase_in    = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  if (overrun) begin
                     cause = CAUSE_OVERRUN;
                  end else if (head.data_byte == 8'd0) begin
                     cause = CAUSE_ZERO_CNT;
                  end else if (!(cur_type_ff inside {[8'd1:8'd4]})) begin
                     cause = CAUSE_BAD_TYPE;
                  end else begin
                     left_in  = head.data_byte;
                     idx_in   = 2'd0;
                     acc_in   = 32'd0;
                     phase_in = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (value_done) begin
                     res_valid        = 1'b1;
                     res.as_number    = four_byte_as ? acc_next : {16'd0, acc_next[15:0]};
                     res.segment_kind = cur_type_ff[1:0] - 2'd1;
                     res.segment_end  = (left_dec == 8'd0);
                     res.path_end     = head.last;
                     res.reject_cause = CAUSE_OK;
                     left_in          = left_dec;
                     idx_in           = 2'd0;
                     acc_in           = 32'd0;
                     if (left_dec == 8'd0) begin
                        phase_in = PH_TYPE;
                     end
                  end else begin
                     idx_in = idx_ff + 2'd1;
                     acc_in = acc_next;
                  end
               end
               default: begin
                  phase_in = PH_TYPE;
               end
            endcase
         end

         // A rejection is the final result of its path.
         if (cause != CAUSE_OK) begin
            res_valid        = 1'b1;
            res              = '0;
            res.path_end     = 1'b1;
            res.reject_cause = cause;
            skip_in          = 1'b1;
         end
      end

      // The last byte of a path returns the parser to its idle state.
      if (head.last) begin
         phase_in    = PH_TYPE;
         cur_type_in = 8'd0;
         left_in     = 8'd0;
         idx_in      = 2'd0;
         acc_in      = 32'd0;
         skip_in     = 1'b0;
      end
   end

   // Parser state advances only when a byte is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         cur_type_ff <= 8'd0;
         left_ff     <= 8'd0;
         idx_ff      <= 2'd0;
         acc_ff      <= 32'd0;
         skip_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         cur_type_ff <= cur_type_in;
         left_ff     <= left_in;
         idx_ff      <= idx_in;
         acc_ff      <= acc_in;
         skip_ff     <= skip_in;
      end
   end

   // Result queue pointers.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// File: rtl/as_path_segment_parser_top.sv
// Top level of the AS_PATH segment parser: front end, back end and the width register.
// A byte passes through the input queue and the back-end parser step; its result is registered in the result queue.
// Throughput: one byte per cycle while the result queue has room; the back-end parser step is combinational.
// Two-entry queues sit between the front and back ends and at the result side.
// Synchronous active-high reset empties both queues, returns the parser to the type phase,
// and clears the four-byte AS setting to two-byte numbers.
module as_path_segment_parser_top
   import aspp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_path_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_as_number,
   output logic [1:0]  rsp_segment_kind,
   output logic        rsp_segment_end,
   output logic        rsp_path_end,
   output logic [2:0]  rsp_reject_cause,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_four_byte_as
);

   logic    four_byte_as_ff, four_byte_as_in;
   logic    head_valid;
   logic    head_pop;
   cls_type head;
   rsp_type rsp_head;

   // Configuration register, always ready for a transfer.
   assign csr_ready       = 1'b1;
   assign four_byte_as_in = (csr_valid && csr_ready) ? csr_four_byte_as : four_byte_as_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         four_byte_as_ff <= 1'b0;
      end else begin
         four_byte_as_ff <= four_byte_as_in;
      end
   end

   aspp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .data_byte   (req_data_byte),
      .path_length (req_path_length),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   aspp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .four_byte_as (four_byte_as_ff),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_head     (rsp_head)
   );

   // Result fields from the head of the result queue.
   assign rsp_as_number    = rsp_head.as_number;
   assign rsp_segment_kind = rsp_head.segment_kind;
   assign rsp_segment_end  = rsp_head.segment_end;
   assign rsp_path_end     = rsp_head.path_end;
   assign rsp_reject_cause = rsp_head.reject_cause;

endmodule

// File: bench/as_path_segment_parser_top_tb.sv
// Self-checking testbench for the AS_PATH segment parser top level.
`timescale 1ns / 100ps

module as_path_segment_parser_top_tb;
   import aspp_pkg::*;

   // Tracks the parser state and holds the results still awaited, AS numbers and rejections.
   class as_path_board;
      rsp_type     awaited[$];
      bit          wide;
      logic [15:0] bytes_seen;
      phase_type   phase;
      logic [7:0]  seg_type;
      logic [7:0]  values_left;
      logic [1:0]  byte_idx;
      logic [31:0] accum;
      bit          skipping;
      int unsigned mismatch_cnt;

      function new();
         wide = 1'b0;
         mismatch_cnt = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         bytes_seen = '0;
         phase = PH_TYPE;
         seg_type = '0;
         values_left = '0;
         byte_idx = '0;
         accum = '0;
         skipping = 1'b0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Advances the parser by one accepted byte and queues any result it causes.
      function void take_byte(logic [7:0] b, logic [15:0] len);
         int unsigned pos;
         int unsigned width;
         int unsigned seg_end;
         bit          last;
         logic [2:0]  cause;
         rsp_type     r;
         pos = bytes_seen;
         last = (pos + 1 >= len);
         width = wide ? 4 : 2;
         cause = CAUSE_OK;
         if (!skipping) begin
            if (pos == 0 && len[0]) begin
               cause = CAUSE_ODD_LEN;
            end else if (phase == PH_TYPE) begin
               if (pos + 2 >= len) begin
                  cause = CAUSE_NEAR_END;
               end else begin
                  seg_type = b;
                  phase = PH_COUNT;
               end
            end else if (phase == PH_COUNT) begin
               // The segment header started one byte before the count byte.
               seg_end = pos - 1 + 2 + b * width;
               if (seg_end > len) begin
                  cause = CAUSE_OVERRUN;
               end else if (b == 8'd0) begin
                  cause = CAUSE_ZERO_CNT;
               end else if (seg_type < 8'd1 || seg_type > 8'd4) begin
                  cause = CAUSE_BAD_TYPE;
               end else begin
                  values_left = b;
                  byte_idx = '0;
                  accum = '0;
                  phase = PH_VALUE;
               end
            end else begin
               accum = {accum[23:0], b};
               if (byte_idx + 1 >= width) begin
                  r.as_number = (width == 2) ? {16'h0000, accum[15:0]} : accum;
                  values_left = values_left - 8'd1;
                  r.segment_kind = seg_type[1:0] - 2'd1;
                  r.segment_end = (values_left == 8'd0);
                  r.path_end = last;
                  r.reject_cause = CAUSE_OK;
                  awaited.push_back(r);
                  byte_idx = '0;
                  accum = '0;
                  if (r.segment_end) phase = PH_TYPE;
               end else begin
                  byte_idx = byte_idx + 2'd1;
               end
            end
            // A rejection is always the final result of its path.
            if (cause != CAUSE_OK) begin
               r = '0;
               r.path_end = 1'b1;
               r.reject_cause = cause;
               awaited.push_back(r);
               skipping = 1'b1;
            end
         end
         if (last) clear_parse();
         else bytes_seen = 16'(pos + 1);
      endfunction

      // Compares one result transfer with the oldest awaited result.
      function void match_rsp(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: result with none awaited:", $realtime,
                        " as %h kind %0d seg %0d path %0d cause %0d",
                        got.as_number, got.segment_kind, got.segment_end,
                        got.path_end, got.reject_cause);
            return;
         end
         want = awaited.pop_front();
         if (got.as_number !== want.as_number || got.segment_kind !== want.segment_kind ||
             got.segment_end !== want.segment_end || got.path_end !== want.path_end ||
             got.reject_cause !== want.reject_cause) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: mismatch: expected as %h kind %0d seg %0d path %0d cause %0d,",
                        $realtime, want.as_number, want.segment_kind, want.segment_end,
                        want.path_end, want.reject_cause,
                        " got as %h kind %0d seg %0d path %0d cause %0d",
                        got.as_number, got.segment_kind,
                        got.segment_end, got.path_end, got.reject_cause);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_path_length = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_as_number;
   logic [1:0]  rsp_segment_kind;
   logic        rsp_segment_end;
   logic        rsp_path_end;
   logic [2:0]  rsp_reject_cause;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_four_byte_as = 1'b0;

   as_path_board board;
   bit           idle_on = 1'b1;
   bit           long_hold_req = 1'b0;
   bit           wide_now = 1'b0;
   int unsigned  sent_bytes = 0;
   logic [7:0]   path_q[$];

   as_path_segment_parser_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_path_length  (req_path_length),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_as_number    (rsp_as_number),
      .rsp_segment_kind (rsp_segment_kind),
      .rsp_segment_end  (rsp_segment_end),
      .rsp_path_end     (rsp_path_end),
      .rsp_reject_cause (rsp_reject_cause),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_four_byte_as (csr_four_byte_as)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one byte, with an optional idle burst first, and waits for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic [15:0] len);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      req_path_length <= len;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.take_byte(b, len);
      sent_bytes++;
   endtask

   // Sends every queued byte with the same path length.
   task automatic send_path(input int unsigned len);
      foreach (path_q[i]) send_byte(path_q[i], len[15:0]);
      path_q.delete();
   endtask

   // Stops offering bytes and waits until the block has nothing left in flight.
   task automatic settle();
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes the AS width register; only called with no bytes or results in flight.
   task automatic write_width(input logic wide);
      csr_valid <= 1'b1;
      csr_four_byte_as <= wide;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.wide = wide;
      wide_now = wide;
   endtask

   task automatic add_segment(input logic [7:0] kind_byte, input int unsigned cnt);
      int unsigned w;
      w = wide_now ? 4 : 2;
      path_q.push_back(kind_byte);
      path_q.push_back(cnt[7:0]);
      repeat (cnt * w) path_q.push_back(8'($urandom));
   endtask

   // Appends well-formed segments; a rare one carries a large count.
   task automatic add_good(input int unsigned n);
      int unsigned cnt;
      repeat (n) begin
         if ($urandom_range(0, 149) == 0) cnt = $urandom_range(1, 255);
         else cnt = $urandom_range(1, 5);
         add_segment(8'($urandom_range(1, 4)), cnt);
      end
   endtask

   // Builds and sends one path: mostly well-formed, the rest broken or noise.
   task automatic send_random_path();
      int unsigned pick;
      int unsigned fill;
      int unsigned cnt;
      int unsigned n;
      int unsigned k;
      int unsigned w;
      w = wide_now ? 4 : 2;
      pick = $urandom_range(0, 99);
      path_q.delete();
      if (pick < 55) begin
         add_good($urandom_range(1, 3));
         send_path(path_q.size());
      end else if (pick < 62) begin
         // Path length drops mid-path, so the path ends early.
         add_good($urandom_range(1, 3));
         n = path_q.size();
         k = $urandom_range(1, n - 2);
         for (int i = 0; i < k; i++) send_byte(path_q[i], n[15:0]);
         send_byte(path_q[k], 16'(k + 1));
         path_q.delete();
      end else if (pick < 70) begin
         n = 2 * $urandom_range(0, 7) + 1;
         repeat (n) path_q.push_back(8'($urandom));
         send_path(n);
      end else if (pick < 76) begin
         add_good($urandom_range(0, 2));
         repeat (2) path_q.push_back(8'($urandom));
         send_path(path_q.size());
      end else if (pick < 82) begin
         add_good($urandom_range(0, 1));
         fill = 2 * $urandom_range(1, 3);
         if ($urandom_range(0, 1) == 0) cnt = $urandom_range(fill / w + 1, 255);
         else cnt = fill / w + 1 + $urandom_range(0, 3);
         path_q.push_back(8'($urandom_range(1, 4)));
         path_q.push_back(cnt[7:0]);
         repeat (fill) path_q.push_back(8'($urandom));
         send_path(path_q.size());
      end else if (pick < 88) begin
         add_good($urandom_range(0, 1));
         path_q.push_back(8'($urandom_range(1, 4)));
         path_q.push_back(8'd0);
         repeat (2 * $urandom_range(1, 3)) path_q.push_back(8'($urandom));
         send_path(path_q.size());
      end else if (pick < 94) begin
         add_good($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 0) add_segment(8'd0, $urandom_range(1, 3));
         else add_segment(8'($urandom_range(5, 255)), $urandom_range(1, 3));
         add_good($urandom_range(0, 1));
         send_path(path_q.size());
      end else begin
         // Noise with a random length, closed by a byte with length zero.
         n = $urandom_range(0, 20);
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom), n[15:0]);
         send_byte(8'($urandom), 16'd0);
      end
   endtask

   // Result side: checks each transfer and stalls in random bursts.
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      rsp_type     got;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.as_number = rsp_as_number;
            got.segment_kind = rsp_segment_kind;
            got.segment_end = rsp_segment_end;
            got.path_end = rsp_path_end;
            got.reject_cause = rsp_reject_cause;
            board.match_rsp(got);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 300;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed paths, then random phases at several widths.
   initial begin : stimulus
      int unsigned phase_start;
      logic        w;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two-byte numbers: largest AS number in a sequence.
      write_width(1'b0);
      path_q = '{8'h02, 8'h01, 8'hFF, 8'hFF};
      send_path(4);
      // Zero path length: a lone byte ends its own path.
      send_byte(8'h00, 16'd0);
      // Largest, odd path length, then a shorter length closes the path.
      send_byte(8'hAA, 16'hFFFF);
      send_byte(8'h55, 16'd1);
      // Path ends in the middle of an AS number; the partial value is dropped.
      send_byte(8'h04, 16'hFFFE);
      send_byte(8'h01, 16'hFFFE);
      send_byte(8'h12, 16'd3);
      // Zero count, bad type, and a count that overruns the path.
      path_q = '{8'h01, 8'h00, 8'h00, 8'h00};
      send_path(4);
      path_q = '{8'h00, 8'h01, 8'h00, 8'h00};
      send_path(4);
      path_q = '{8'h01, 8'hFF, 8'h00, 8'h00};
      send_path(4);
      settle();

      // Four-byte numbers: largest AS number in a confed sequence.
      write_width(1'b1);
      path_q = '{8'h03, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_path(6);
      // Width drops to two bytes in the middle of a value; a header near the end follows.
      path_q = '{8'h01, 8'h01, 8'hAB, 8'hCD};
      send_path(6);
      settle();
      write_width(1'b0);
      send_byte(8'hEF, 16'd6);
      send_byte(8'h77, 16'd6);

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         idle_on = (ph != 7);
         case (ph)
            0, 3: w = 1'b0;
            1, 2: w = 1'b1;
            default: w = 1'($urandom_range(0, 1));
         endcase
         write_width(w);
         // Receiver holds off long enough for the input side to fill and stall.
         if (ph == 2) long_hold_req = 1'b1;
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < 200) send_random_path();
      end

      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatch_cnt == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: as_path_segment_parser_top.f
rtl/aspp_pkg.sv
rtl/aspp_front.sv
rtl/aspp_back.sv
rtl/as_path_segment_parser_top.sv
bench/as_path_segment_parser_top_tb.sv
